// ----- src/lzp_pkg.sv -----
// ----------------------------------------------------------------------------
// lzp_pkg
// Shared constants and types of the plain LZ77 decompressor.
// ----------------------------------------------------------------------------
package lzp_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 8192;
  localparam int unsigned DRAIN_MAX_DEF    = 64;
  localparam int unsigned MAX_RESULTS      = 64;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned LEN_W            = 25;

  localparam logic [1:0] REQ_FEED  = 2'd0;
  localparam logic [1:0] REQ_DRAIN = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_OFFSET  = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  localparam logic [2:0] PH_FLAG     = 3'd0;
  localparam logic [2:0] PH_TOKEN    = 3'd1;
  localparam logic [2:0] PH_MATCH_HI = 3'd2;
  localparam logic [2:0] PH_NIBBLE   = 3'd3;
  localparam logic [2:0] PH_EXT8     = 3'd4;
  localparam logic [2:0] PH_EXT16    = 3'd5;
  localparam logic [2:0] PH_EXT32    = 3'd6;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       done;
    logic       pend;
    logic       last;
  } res_t;

endpackage

// ----- src/lzp_history.sv -----
// ----------------------------------------------------------------------------
// lzp_history
// History window: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzp_history #(
  parameter int unsigned Depth = lzp_pkg::WINDOW_BYTES_DEF,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lz77_plain_decompressor_top.sv -----
// ----------------------------------------------------------------------------
// lz77_plain_decompressor_top
// Streaming plain LZ77 decoder with an 8 KiB history window.
// ----------------------------------------------------------------------------
// Without output stalls a feed item that parses a header, token or literal byte
// passes through accept, check and finish; a feed that ends in an offset or
// overrun report goes from accept straight to finish. Each match byte takes a
// history read, then a write and emit, on the single history memory port pair.
// The block is not ready while an item is in work. Results pass through a
// one-entry hold and an output register, so a stalled consumer only holds the
// sequencer.
module lz77_plain_decompressor_top #(
  parameter int unsigned WINDOW_BYTES = lzp_pkg::WINDOW_BYTES_DEF,
  parameter int unsigned DRAIN_MAX    = lzp_pkg::DRAIN_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lzp_pkg::LEN_W-1:0] output_length_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic [1:0]               status_o,
  output logic                     message_done_o,
  output logic                     copy_pending_o,
  output logic                     run_last_o
);
  import lzp_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRD  = 3'd1;
  localparam logic [2:0] S_CEM  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] prod_q, prod_d;
  logic [31:0]      flag_q, flag_d;
  logic [5:0]       fleft_q, fleft_d;
  logic [2:0]       ph_q, ph_d;
  logic [31:0]      acc_q, acc_d;
  logic [2:0]       idx_q, idx_d;
  logic [13:0]      off_q, off_d;
  logic [3:0]       nib_q, nib_d;
  logic             nibv_q, nibv_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             err_q, err_d;
  logic             end_q, end_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0] n_q, n_d;
  res_t             hold_q, out_q, stage_res;
  logic             hold_v_q, out_v_q;
  logic             stage_en, push, push_last, out_free;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [LEN_W-1:0] src_pos;

  lzp_history #(
    .Depth(WINDOW_BYTES)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !out_v_q || out_ready_i;
  assign src_pos   = prod_q - {{(LEN_W-14){1'b0}}, off_q};
  assign ram_raddr = src_pos[AW-1:0];
  assign ram_waddr = prod_q[AW-1:0];

  always_comb begin
    logic             start_m;
    logic [32:0]      m_len;
    logic [4:0]       fl;
    logic [3:0]       nib;
    logic             nib_go;
    logic [15:0]      v16;
    logic [33:0]      sum;
    logic             trunc_due;
    logic [LEN_W-1:0] prod_inc;
    logic [31:0]      bsh;

    st_d   = st_q;   prod_d = prod_q; flag_d = flag_q; fleft_d = fleft_q;
    ph_d   = ph_q;   acc_d  = acc_q;  idx_d  = idx_q;  off_d   = off_q;
    nib_d  = nib_q;  nibv_d = nibv_q; rem_d  = rem_q;  err_d   = err_q;
    end_d  = end_q;  cnt_d  = cnt_q;  lim_d  = lim_q;  n_d     = n_q;
    stage_en  = 1'b0;
    stage_res = '0;
    push      = 1'b0;
    push_last = 1'b0;
    in_ready_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ram_rdata;
    start_m   = 1'b0;
    m_len     = '0;
    fl        = fleft_q[4:0] - 5'd1;
    nib       = '0;
    nib_go    = 1'b0;
    v16       = '0;
    sum       = '0;
    trunc_due = 1'b0;
    prod_inc  = prod_q + LEN_W'(1);
    bsh       = {24'd0, in_byte_i} << {idx_q[1:0], 3'b000};

    unique case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d = '0;
          unique case (req_type_i)
            REQ_START: begin
              prod_d = '0; flag_d = '0; fleft_d = '0; ph_d = PH_FLAG;
              acc_d = '0; idx_d = '0; off_d = '0; nib_d = '0; nibv_d = 1'b0;
              rem_d = '0; err_d = 1'b0; end_d = 1'b0;
            end
            REQ_FEED: begin
              if (!(err_q || end_q || rem_q != '0 || prod_q >= len_q)) begin
                end_d = end_q | in_last_i;
                st_d  = S_CHK;
                case (ph_q)
                  PH_TOKEN: begin
                    fleft_d = {1'b0, fl};
                    if (!flag_q[fl]) begin
                      ram_we    = 1'b1;
                      ram_wdata = in_byte_i;
                      prod_d    = prod_inc;
                      stage_en  = 1'b1;
                      stage_res = '{data: in_byte_i, status: ST_DATA,
                                    done: prod_inc == len_q, pend: 1'b0, last: 1'b0};
                      n_d   = CNT_W'(1);
                      ph_d  = (fl != '0) ? PH_TOKEN : PH_FLAG;
                      acc_d = '0;
                      idx_d = '0;
                    end else begin
                      acc_d = {24'd0, in_byte_i};
                      ph_d  = PH_MATCH_HI;
                    end
                  end
                  PH_MATCH_HI: begin
                    v16   = {in_byte_i, acc_q[7:0]};
                    off_d = {1'b0, v16[15:3]} + 14'd1;
                    if (v16[2:0] != 3'h7) begin
                      start_m = 1'b1;
                      m_len   = {30'd0, v16[2:0]} + 33'd3;
                    end else if (nibv_q) begin
                      nibv_d = 1'b0;
                      nib_go = 1'b1;
                      nib    = nib_q;
                    end else begin
                      ph_d = PH_NIBBLE;
                    end
                  end
                  PH_NIBBLE: begin
                    nib_d  = in_byte_i[7:4];
                    nibv_d = 1'b1;
                    nib_go = 1'b1;
                    nib    = in_byte_i[3:0];
                  end
                  PH_EXT8: begin
                    if (in_byte_i != 8'hff) begin
                      start_m = 1'b1;
                      m_len   = {25'd0, in_byte_i} + 33'd25;
                    end else begin
                      ph_d  = PH_EXT16;
                      acc_d = '0;
                      idx_d = '0;
                    end
                  end
                  PH_EXT16: begin
                    acc_d = acc_q | bsh;
                    idx_d = idx_q + 3'd1;
                    if (idx_q[0]) begin
                      v16 = {in_byte_i, acc_q[7:0]};
                      if (v16 != '0) begin
                        start_m = 1'b1;
                        m_len   = {17'd0, v16} + 33'd3;
                      end else begin
                        ph_d  = PH_EXT32;
                        acc_d = '0;
                        idx_d = '0;
                      end
                    end
                  end
                  PH_EXT32: begin
                    acc_d = acc_q | bsh;
                    idx_d = idx_q + 3'd1;
                    if (idx_q[1:0] == 2'd3) begin
                      start_m = 1'b1;
                      m_len   = {1'b0, in_byte_i, acc_q[23:0]} + 33'd3;
                    end
                  end
                  default: begin
                    acc_d = acc_q | bsh;
                    idx_d = idx_q + 3'd1;
                    if (idx_q[1:0] == 2'd3) begin
                      flag_d  = {in_byte_i, acc_q[23:0]};
                      fleft_d = 6'd32;
                      ph_d    = PH_TOKEN;
                      acc_d   = '0;
                      idx_d   = '0;
                    end
                  end
                endcase
                if (nib_go) begin
                  if (nib != 4'hf) begin
                    start_m = 1'b1;
                    m_len   = {29'd0, nib} + 33'd10;
                  end else begin
                    ph_d = PH_EXT8;
                  end
                end
                if (start_m) begin
                  ph_d  = (fleft_d != '0) ? PH_TOKEN : PH_FLAG;
                  acc_d = '0;
                  idx_d = '0;
                  sum   = {9'd0, prod_q} + {1'b0, m_len};
                  if ({11'd0, off_d} > prod_q) begin
                    stage_en  = 1'b1;
                    stage_res = '{data: 8'd0, status: ST_OFFSET, done: 1'b0,
                                  pend: 1'b0, last: 1'b0};
                    err_d = 1'b1;
                    rem_d = '0;
                    st_d  = S_FIN;
                  end else if (sum > {9'd0, len_q}) begin
                    stage_en  = 1'b1;
                    stage_res = '{data: 8'd0, status: ST_OVERRUN, done: 1'b0,
                                  pend: 1'b0, last: 1'b0};
                    err_d = 1'b1;
                    rem_d = '0;
                    st_d  = S_FIN;
                  end else begin
                    rem_d     = m_len[LEN_W-1:0];
                    trunc_due = end_d && (sum < {9'd0, len_q});
                    lim_d     = (trunc_due && DRAIN_MAX > MAX_RESULTS - 1) ?
                                CNT_W'(MAX_RESULTS - 1) : CNT_W'(DRAIN_MAX);
                    cnt_d     = '0;
                    st_d      = S_CRD;
                  end
                end
              end
            end
            REQ_DRAIN: begin
              if (!err_q && rem_q != '0) begin
                sum       = {9'd0, prod_q} + {9'd0, rem_q};
                trunc_due = end_q && (sum < {9'd0, len_q});
                lim_d     = (trunc_due && DRAIN_MAX > MAX_RESULTS - 1) ?
                            CNT_W'(MAX_RESULTS - 1) : CNT_W'(DRAIN_MAX);
                cnt_d     = '0;
                st_d      = S_CRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CRD: begin
        if (rem_q == '0 || cnt_q == lim_q) begin
          st_d = S_CHK;
        end else begin
          ram_re = 1'b1;
          st_d   = S_CEM;
        end
      end
      S_CEM: begin
        if (!hold_v_q || out_free) begin
          push      = hold_v_q;
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          prod_d    = prod_inc;
          rem_d     = rem_q - LEN_W'(1);
          cnt_d     = cnt_q + CNT_W'(1);
          n_d       = n_q + CNT_W'(1);
          stage_en  = 1'b1;
          stage_res = '{data: ram_rdata, status: ST_DATA, done: prod_inc == len_q,
                        pend: rem_q != LEN_W'(1), last: 1'b0};
          st_d      = S_CRD;
        end
      end
      S_CHK: begin
        if (end_q && !err_q && rem_q == '0 && prod_q < len_q &&
            n_q < CNT_W'(MAX_RESULTS)) begin
          if (!hold_v_q || out_free) begin
            push      = hold_v_q;
            stage_en  = 1'b1;
            stage_res = '{data: 8'd0, status: ST_TRUNC, done: 1'b0,
                          pend: 1'b0, last: 1'b0};
            err_d     = 1'b1;
            st_d      = S_FIN;
          end
        end else begin
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!hold_v_q) begin
          st_d = S_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          st_d      = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; len_q <= '0; prod_q <= '0; flag_q <= '0; fleft_q <= '0;
      ph_q <= PH_FLAG; acc_q <= '0; idx_q <= '0; off_q <= '0; nib_q <= '0;
      nibv_q <= 1'b0; rem_q <= '0; err_q <= 1'b0; end_q <= 1'b0;
      cnt_q <= '0; lim_q <= '0; n_q <= '0;
      hold_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; prod_q <= prod_d; flag_q <= flag_d; fleft_q <= fleft_d;
      ph_q <= ph_d; acc_q <= acc_d; idx_q <= idx_d; off_q <= off_d; nib_q <= nib_d;
      nibv_q <= nibv_d; rem_q <= rem_d; err_q <= err_d; end_q <= end_d;
      cnt_q <= cnt_d; lim_q <= lim_d; n_q <= n_d;
      if (cfg_valid_i) begin
        len_q <= output_length_i;
      end
      if (stage_en) begin
        hold_v_q <= 1'b1;
      end else if (push) begin
        hold_v_q <= 1'b0;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      hold_q <= stage_res;
    end
    if (push) begin
      out_q <= '{data: hold_q.data, status: hold_q.status, done: hold_q.done,
                 pend: hold_q.pend, last: push_last};
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_v_q;
  assign out_byte_o     = out_q.data;
  assign status_o       = out_q.status;
  assign message_done_o = out_q.done;
  assign copy_pending_o = out_q.pend;
  assign run_last_o     = out_q.last;

  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> !hold_v_q)
    else $error("hold entry left over at item end");

  a_err_no_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> rem_q == '0)
    else $error("copy pending while error latched");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.status != ST_DATA |-> out_q.last)
    else $error("error result not last of its item");

endmodule

// ----- dv/lz77_plain_decompressor_top_tb.sv -----
// ----------------------------------------------------------------------------
// lz77_plain_decompressor_top_tb
// Self-checking bench for the plain LZ77 decoder. An encoder in the bench builds
// compressed messages, both well formed and broken, and a cycle-free model of
// the decoder predicts every output item. Results are compared field by field
// under random idling on the input, output and configuration channels.
// ----------------------------------------------------------------------------
module lz77_plain_decompressor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lzp_pkg::*;

  typedef enum logic [1:0] {K_DATA, K_CFG, K_PAUSE} kind_e;
  typedef enum int {F_SHORT, F_NIB, F_EXT8, F_EXT16, F_EXT32} form_e;
  typedef struct {
    kind_e       kind;
    logic [1:0]  req;
    logic [7:0]  b;
    logic        last;
    logic [24:0] val;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LEN_W-1:0] output_length_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type_i = REQ_DRAIN;
  logic [7:0] in_byte_i = '0;
  logic in_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic message_done_o, copy_pending_o, run_last_o;

  lz77_plain_decompressor_top u_dut (.*);

  always #1 clk_i = ~clk_i;

  item_t pend_q[$];
  res_t  exp_q[$];
  int    errs = 0;
  int    checked = 0;
  int    n_msgs = 0;
  int    n_err_items = 0;
  int    n_feeds = 0;

  task automatic report(input string what);
    $display("%0t MISMATCH: %s", $realtime, what);
    errs++;
  endtask

  // ---------------- decoder model ----------------
  logic [7:0]  hist [8192];
  logic [24:0] m_len, m_cnt, m_rem;
  logic [31:0] m_flags, m_acc;
  logic [2:0]  m_phase;
  logic [3:0]  m_nib;
  int unsigned m_left, m_idx, m_off;
  bit          m_nibv, m_err, m_ended;
  int          m_n;

  task automatic clear_msg();
    m_cnt = 0; m_flags = 0; m_left = 0; m_phase = PH_FLAG; m_acc = 0; m_idx = 0;
    m_off = 0; m_nib = 0; m_nibv = 0; m_rem = 0; m_err = 0; m_ended = 0;
  endtask

  task automatic put_plain(input logic [7:0] b);
    res_t r;
    hist[m_cnt[12:0]] = b;
    m_cnt = m_cnt + 1;
    r = '{data: b, status: ST_DATA, done: m_cnt == m_len, pend: m_rem != 0, last: 1'b0};
    exp_q.push_back(r);
    m_n++;
  endtask

  task automatic flag_error(input logic [1:0] code);
    exp_q.push_back('{data: 8'h00, status: code, done: 1'b0, pend: 1'b0, last: 1'b0});
    m_err = 1; m_rem = 0; m_n++;
    n_err_items++;
  endtask

  task automatic copy_run();
    int lim;
    logic [24:0] src;
    lim = DRAIN_MAX_DEF;
    if (m_ended && !m_err && (longint'(m_cnt) + m_rem < longint'(m_len)) &&
        lim > MAX_RESULTS - 1)
      lim = MAX_RESULTS - 1;
    for (int i = 0; i < lim && m_rem != 0; i++) begin
      src = m_cnt - m_off;
      m_rem = m_rem - 1;
      put_plain(hist[src[12:0]]);
    end
  endtask

  task automatic end_tok();
    m_phase = (m_left != 0) ? PH_TOKEN : PH_FLAG;
    m_acc = 0; m_idx = 0;
  endtask

  task automatic begin_match(input longint len);
    end_tok();
    if (m_off > m_cnt) flag_error(ST_OFFSET);
    else if (longint'(m_cnt) + len > longint'(m_len)) flag_error(ST_OVERRUN);
    else begin
      m_rem = len[24:0];
      copy_run();
    end
  endtask

  task automatic resolve_nib(input logic [3:0] nib);
    if (nib < 15) begin_match(nib + 10);
    else m_phase = PH_EXT8;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] tok;
    case (m_phase)
      PH_TOKEN: begin
        m_left = (m_left - 1) & 31;
        if (!m_flags[m_left]) begin
          put_plain(b);
          end_tok();
        end else begin
          m_acc = {24'b0, b};
          m_phase = PH_MATCH_HI;
        end
      end
      PH_MATCH_HI: begin
        tok = {b, m_acc[7:0]};
        m_off = tok[15:3] + 1;
        if (tok[2:0] != 3'd7) begin_match(tok[2:0] + 3);
        else if (m_nibv) begin
          m_nibv = 0;
          resolve_nib(m_nib);
        end else m_phase = PH_NIBBLE;
      end
      PH_NIBBLE: begin
        m_nib = b[7:4];
        m_nibv = 1;
        resolve_nib(b[3:0]);
      end
      PH_EXT8: begin
        if (b < 8'd255) begin_match(b + 25);
        else begin
          m_phase = PH_EXT16; m_acc = 0; m_idx = 0;
        end
      end
      PH_EXT16: begin
        m_acc = m_acc | ({24'b0, b} << (8 * (m_idx & 1)));
        m_idx++;
        if (m_idx >= 2) begin
          if (m_acc[15:0] != 0) begin_match(m_acc[15:0] + 3);
          else begin
            m_phase = PH_EXT32; m_acc = 0; m_idx = 0;
          end
        end
      end
      PH_EXT32: begin
        m_acc = m_acc | ({24'b0, b} << (8 * (m_idx & 3)));
        m_idx++;
        if (m_idx >= 4) begin_match(longint'(m_acc) + 3);
      end
      default: begin
        m_acc = m_acc | ({24'b0, b} << (8 * (m_idx & 3)));
        m_idx++;
        if (m_idx >= 4) begin
          m_flags = m_acc; m_left = 32; m_phase = PH_TOKEN; m_acc = 0; m_idx = 0;
        end
      end
    endcase
  endtask

  task automatic decode_item(input logic [1:0] req, input logic [7:0] b, input logic last);
    m_n = 0;
    if (req == REQ_START) begin
      clear_msg();
      return;
    end
    if (req == REQ_FEED) begin
      if (m_err || m_ended || m_rem != 0 || m_cnt >= m_len) return;
      if (last) m_ended = 1;
      parse_byte(b);
    end else if (req == REQ_DRAIN) begin
      if (m_err || m_rem == 0) return;
      copy_run();
    end else return;
    if (m_ended && !m_err && m_rem == 0 && m_cnt < m_len && m_n < MAX_RESULTS)
      flag_error(ST_TRUNC);
    if (m_n > 0) exp_q[$].last = 1'b1;
  endtask

  // ---------------- message encoder ----------------
  item_t msg[$];
  int    e_prod, e_grp, e_flag_at, e_nib_at, e_last_at;
  logic [31:0] e_flags;

  task automatic push_feed(input logic [7:0] b);
    msg.push_back('{kind: K_DATA, req: REQ_FEED, b: b, last: 1'b0, val: '0});
    e_last_at = msg.size() - 1;
  endtask

  task automatic push_drain();
    msg.push_back('{kind: K_DATA, req: REQ_DRAIN, b: 8'($urandom), last: 1'b0, val: '0});
  endtask

  task automatic enc_begin();
    msg.delete();
    e_prod = 0; e_grp = 32; e_nib_at = -1; e_last_at = -1;
  endtask

  task automatic tok_flag(input bit is_copy);
    if (e_grp == 32) begin
      e_flag_at = msg.size();
      for (int k = 0; k < 4; k++) push_feed(8'h00);
      e_flags = 0; e_grp = 0;
    end
    e_flags[31 - e_grp] = is_copy;
    e_grp++;
    for (int k = 0; k < 4; k++) msg[e_flag_at + k].b = e_flags[8*k +: 8];
  endtask

  task automatic put_lit(input logic [7:0] b);
    tok_flag(0);
    push_feed(b);
    e_prod++;
  endtask

  task automatic put_nib(input logic [3:0] v);
    if (e_nib_at < 0) begin
      push_feed({4'($urandom), v});
      e_nib_at = msg.size() - 1;
    end else begin
      msg[e_nib_at].b[7:4] = v;
      e_nib_at = -1;
    end
  endtask

  task automatic put_match(input int len, input int off, input form_e f);
    logic [15:0] tok;
    logic [31:0] v;
    tok_flag(1);
    tok = {13'(off - 1), (f == F_SHORT) ? 3'(len - 3) : 3'd7};
    push_feed(tok[7:0]);
    push_feed(tok[15:8]);
    if (f == F_NIB) put_nib(4'(len - 10));
    else if (f != F_SHORT) begin
      put_nib(4'd15);
      if (f == F_EXT8) push_feed(8'(len - 25));
      else begin
        push_feed(8'hFF);
        v = len - 3;
        if (f == F_EXT16) begin
          push_feed(v[7:0]); push_feed(v[15:8]);
        end else begin
          push_feed(8'h00); push_feed(8'h00);
          for (int k = 0; k < 4; k++) push_feed(v[8*k +: 8]);
        end
      end
    end
    e_prod += len;
    for (int k = 0; k <= len / 64; k++) push_drain();
  endtask

  function automatic form_e pick_form(input int len);
    form_e opts[$];
    if (len <= 9) opts.push_back(F_SHORT);
    if (len >= 10 && len <= 24) opts.push_back(F_NIB);
    if (len >= 25 && len <= 279) opts.push_back(F_EXT8);
    if (len >= 4 && len <= 65538) opts.push_back(F_EXT16);
    opts.push_back(F_EXT32);
    return opts[$urandom_range(0, opts.size() - 1)];
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(3, 24);
    if (r < 95) return $urandom_range(25, 300);
    return $urandom_range(301, 1200);
  endfunction

  task automatic push_cfg(input logic [24:0] v);
    pend_q.push_back('{kind: K_CFG, req: REQ_FEED, b: 8'h00, last: 1'b0, val: v});
  endtask

  task automatic push_pause();
    pend_q.push_back('{kind: K_PAUSE, req: REQ_FEED, b: 8'h00, last: 1'b0, val: '0});
  endtask

  task automatic flush_msg(input logic [24:0] len);
    push_cfg(len);
    pend_q.push_back('{kind: K_DATA, req: REQ_START, b: 8'($urandom), last: 1'b0, val: '0});
    if (e_last_at >= 0) msg[e_last_at].last = 1'b1;
    foreach (msg[i]) pend_q.push_back(msg[i]);
    n_feeds += msg.size() + 1;
    n_msgs++;
  endtask

  task automatic rand_msg();
    int mode, ntok, bad_at, len, off, slack;
    mode = $urandom_range(0, 9);
    ntok = $urandom_range(2, 40);
    bad_at = $urandom_range(1, ntok - 1);
    enc_begin();
    if (mode == 9) begin
      for (int i = 0; i < ntok; i++)
        msg.push_back('{kind: K_DATA, req: 2'($urandom_range(0, 2)), b: 8'($urandom),
                        last: ($urandom_range(0, 15) == 0), val: '0});
      flush_msg(25'($urandom_range(0, 300)));
      return;
    end
    for (int i = 0; i < ntok; i++) begin
      if (mode == 6 && i == bad_at && e_prod < 8192)
        put_match(pick_len(), $urandom_range(e_prod + 1, 8192), F_SHORT);
      else if (e_prod == 0 || $urandom_range(0, 1) == 0) put_lit(8'($urandom));
      else begin
        len = pick_len();
        off = $urandom_range(1, (e_prod < 8192) ? e_prod : 8192);
        put_match(len, off, pick_form(len));
      end
    end
    slack = $urandom_range(1, 80);
    if (mode == 7) flush_msg(25'((e_prod > slack) ? e_prod - slack : 1));
    else if (mode == 8) flush_msg(25'(e_prod + slack));
    else flush_msg(25'(e_prod));
  endtask

  initial begin
    // zero length: everything is ignored
    push_cfg(25'd0);
    enc_begin();
    push_feed(8'hFF); push_drain(); push_feed(8'h00);
    flush_msg(25'd0);
    push_pause();
    // a length of 2^24 with a short message ends truncated
    enc_begin();
    put_lit(8'h00); put_lit(8'hFF); put_match(3, 1, F_SHORT);
    flush_msg(25'h1000000);
    // every length escape, shared nibble, feed while copy pending, feed after last
    enc_begin();
    put_lit(8'hA5); put_lit(8'h5A);
    put_match(9, 2, F_SHORT);
    put_match(10, 1, F_NIB);
    put_match(24, 3, F_NIB);
    put_match(25, 7, F_EXT8);
    put_match(279, 40, F_EXT8);
    put_match(200, 100, F_EXT16);
    msg.insert(msg.size() - 4, '{kind: K_DATA, req: REQ_FEED, b: 8'h3C, last: 1'b0, val: '0});
    put_match(4, 1, F_EXT16);
    put_match(5, 9, F_EXT32);
    put_lit(8'h7E);
    flush_msg(25'(e_prod));
    pend_q.push_back('{kind: K_DATA, req: REQ_FEED, b: 8'h11, last: 1'b1, val: '0});
    // offset before start, then the error latches
    enc_begin();
    put_lit(8'h01); put_match(3, 5, F_SHORT); put_lit(8'h02);
    flush_msg(25'd50);
    // overrun
    enc_begin();
    put_lit(8'h03); put_match(9, 1, F_SHORT);
    flush_msg(25'd5);
    // truncation behind a long final copy
    enc_begin();
    put_lit(8'h44); put_match(100, 1, F_EXT8);
    flush_msg(25'(e_prod + 10));
    push_pause();
    // full window reach
    enc_begin();
    put_lit(8'h9C); put_lit(8'h21); put_match(8190, 1, F_EXT16);
    put_match(9, 8192, F_SHORT); put_lit(8'hC3);
    flush_msg(25'(e_prod));
    do begin
      rand_msg();
      if ($urandom_range(0, 3) == 0) push_pause();
    end while (n_feeds < 200);
  end

  // ---------------- driver ----------------
  int  in_gap = 0, settle = 0, sent = 0;
  bit  calm;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    bit nv, ncv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      nv = in_valid_i;
      ncv = cfg_valid_i;
      calm = ((sent / 40) % 3) == 1;
      if (in_valid_i && in_ready_o) begin
        decode_item(req_type_i, in_byte_i, in_last_i);
        nv = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        m_len = output_length_i;
        ncv = 0;
        void'(pend_q.pop_front());
      end
      if (exp_q.size() != 0 || nv || ncv) settle <= 0;
      else if (settle < 1000) settle <= settle + 1;
      if (!nv && !ncv && pend_q.size() != 0) begin
        if (in_gap != 0) in_gap <= in_gap - 1;
        else case (pend_q[0].kind)
          K_DATA: begin
            it = pend_q.pop_front();
            req_type_i <= it.req;
            in_byte_i <= it.b;
            in_last_i <= it.last;
            nv = 1;
            sent++;
            in_gap <= draw_wait();
          end
          K_CFG: if (settle >= 16) begin
            output_length_i <= pend_q[0].val;
            ncv = 1;
          end
          default: if (settle >= 16) void'(pend_q.pop_front());
        endcase
      end
      in_valid_i <= nv;
      cfg_valid_i <= ncv;
    end
  end

  // ---------------- monitor ----------------
  int out_stall = 0;

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    int s;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      s = out_stall;
      if (out_valid_o && out_ready_i) begin
        checked++;
        if (exp_q.size() == 0) report("output item with nothing expected");
        else begin
          e = exp_q.pop_front();
          check_field("out_byte", out_byte_o, e.data);
          check_field("status", status_o, e.status);
          check_field("message_done", message_done_o, e.done);
          check_field("copy_pending", copy_pending_o, e.pend);
          check_field("run_last", run_last_o, e.last);
        end
        s = draw_wait();
      end
      if (s != 0) begin
        out_ready_i <= 1'b0;
        out_stall <= s - 1;
      end else begin
        out_ready_i <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  // ---------------- run control ----------------
  initial begin
    clear_msg();
    m_len = 0;
    foreach (hist[i]) hist[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || cfg_valid_i || exp_q.size() != 0);
    repeat (300) @(posedge clk_i);
    if (exp_q.size() != 0) report($sformatf("%0d expected items never came", exp_q.size()));
    $display("Run covered %0d messages and %0d input items; %0d output items checked,",
             n_msgs, sent, checked);
    $display("including %0d error reports.", n_err_items);
    if (errs == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
